@@ rtl/core/mlcs_pkg.sv @@
// Shared definitions for the linear congruence solver.
// Holds the operand width, the counter width and the result record.
// No dependencies; used by every module of the block.
package mlcs_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);

    typedef struct packed {
        logic [WIDTH-1:0] solution;
        logic [WIDTH-1:0] reduced_modulus;
        logic             no_solution;
    } res_t;

endpackage

@@ rtl/core/modular_linear_congruence_solver.sv @@
// Solves divisor * x == dividend modulo a configured modulus.
// Input request on s_axis: tdata holds dividend (bits 31:0) and divisor
// (bits 63:32). Result request on m_axis: tdata holds solution (bits 31:0)
// and reduced_modulus (bits 63:32); tuser carries no_solution.
// The modulus is written on the cfg channel, which is always ready and must
// only be written while the block is idle; it resets to 1.
// One request is worked on at a time, and s_axis_tready stays low meanwhile.
// Latency depends on the operands: the gcd and the extended Euclidean steps
// each run through one shift-subtract divider, the Euclidean steps also
// accumulating the quotient times t, and the final product is built bit
// by bit on the shared modular adder. A zero modulus register skips all
// of this and answers with no_solution set.
// The result sits in an output register: the next request is accepted
// while a result is still waiting for m_axis_tready, and the sequencer
// holds its finished result only while that register is still full.
// Reset (rst_n low, asynchronous) empties the output and returns to idle.
// Depends on mlcs_pkg, mlcs_core and mlcs_modadd.
module modular_linear_congruence_solver
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // dividend [31:0], divisor [63:32]
    input  logic [2*mlcs_pkg::WIDTH-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // solution [31:0], reduced_modulus [63:32]
    output logic [2*mlcs_pkg::WIDTH-1:0]   m_axis_tdata,
    // no_solution [0]
    output logic                           m_axis_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mlcs_pkg::WIDTH-1:0]     cfg_data
);

    localparam int W = mlcs_pkg::WIDTH;

    logic [W-1:0]   modulus_reg, modulus_next;
    logic           out_valid_reg, out_valid_next;
    mlcs_pkg::res_t out_reg, out_next;

    logic           core_idle;
    logic           core_valid;
    logic           core_take;
    mlcs_pkg::res_t core_res;

    mlcs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid & core_idle),
        .dividend  (s_axis_tdata[W-1:0]),
        .divisor   (s_axis_tdata[2*W-1:W]),
        .modulus   (modulus_reg),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res_take  (core_take),
        .res       (core_res)
    );

    assign core_take = core_valid & (~out_valid_reg | m_axis_tready);

    always_comb
    begin
        modulus_next   = cfg_valid ? cfg_data : modulus_reg;
        out_next       = core_take ? core_res : out_reg;
        out_valid_next = out_valid_reg;
        if (core_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = core_idle;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.reduced_modulus, out_reg.solution};
    assign m_axis_tuser  = out_reg.no_solution;

endmodule

@@ rtl/core/mlcs_modadd.sv @@
// Shared modular adder/subtractor of the solver.
// Computes (x + y) mod m or (x - y) mod m for operands already below m.
// Depends on mlcs_pkg.
module mlcs_modadd
(
    input  logic [mlcs_pkg::WIDTH-1:0] x,
    input  logic [mlcs_pkg::WIDTH-1:0] y,
    input  logic [mlcs_pkg::WIDTH-1:0] m,
    input  logic                       sub,
    output logic [mlcs_pkg::WIDTH-1:0] r
);

    localparam int W = mlcs_pkg::WIDTH;

    logic [W-1:0] room;
    logic [W-1:0] lim;
    logic         wrap;

    // room is the distance from y up to the modulus; an add wraps once x
    // reaches it, and a borrowing subtract must add it back.
    assign room = m - y;
    assign lim  = sub ? y : room;
    assign wrap = (x >= lim);

    always_comb
    begin
        if (sub)
        begin
            r = wrap ? (x - y) : (x + room);
        end
        else
        begin
            r = wrap ? (x - room) : (x + y);
        end
    end

endmodule

@@ rtl/core/mlcs_core.sv @@
// Sequencer and datapath of the solver: gcd, reductions, extended Euclid
// and the final modular product, all on one shift-subtract divider and one
// shared modular adder. Depends on mlcs_pkg and mlcs_modadd.
module mlcs_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mlcs_pkg::WIDTH-1:0] dividend,
    input  logic [mlcs_pkg::WIDTH-1:0] divisor,
    input  logic [mlcs_pkg::WIDTH-1:0] modulus,
    output logic                       idle,
    output logic                       res_valid,
    input  logic                       res_take,
    output mlcs_pkg::res_t             res
);

    localparam int W  = mlcs_pkg::WIDTH;
    localparam int CW = mlcs_pkg::CNT_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_GCD_CHK = 4'd1;
    localparam logic [3:0] S_ALIGN   = 4'd2;
    localparam logic [3:0] S_DIV     = 4'd3;
    localparam logic [3:0] S_DIVADD  = 4'd4;
    localparam logic [3:0] S_NEXT    = 4'd5;
    localparam logic [3:0] S_EXT_CHK = 4'd6;
    localparam logic [3:0] S_EXT_T   = 4'd7;
    localparam logic [3:0] S_MUL     = 4'd8;
    localparam logic [3:0] S_MULADD  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    localparam logic [2:0] P_GCD  = 3'd0;
    localparam logic [2:0] P_QA   = 3'd1;
    localparam logic [2:0] P_QB   = 3'd2;
    localparam logic [2:0] P_QM   = 3'd3;
    localparam logic [2:0] P_BMOD = 3'd4;
    localparam logic [2:0] P_EXT  = 3'd5;
    localparam logic [2:0] P_AMOD = 3'd6;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic        stage_reg, stage_next;
    logic        ext_reg, ext_next;
    logic        bit_reg, bit_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] m_reg, m_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] y_reg, y_next;
    logic [W-1:0] n_reg, n_next;
    logic [W:0]   d_reg, d_next;
    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] r0_reg, r0_next;
    logic [W-1:0] r1_reg, r1_next;
    logic [W-1:0] t0_reg, t0_next;
    logic [W-1:0] t1_reg, t1_next;
    logic [W-1:0] acc_reg, acc_next;
    mlcs_pkg::res_t res_reg, res_next;

    // division launch
    logic         div_start;
    logic [W-1:0] div_n;
    logic [W-1:0] div_d;
    logic         div_ext;
    logic [2:0]   div_phase;

    // shared modular adder
    logic [W-1:0] ma_x;
    logic [W-1:0] ma_y;
    logic         ma_sub;
    logic [W-1:0] ma_r;

    logic [W:0]   d_dbl;
    logic         qbit;

    assign d_dbl = {d_reg[W-1:0], 1'b0};
    assign qbit  = ({1'b0, n_reg} >= d_reg);

    mlcs_modadd u_modadd
    (
        .x   (ma_x),
        .y   (ma_y),
        .m   (m_reg),
        .sub (ma_sub),
        .r   (ma_r)
    );

    always_comb
    begin
        ma_x   = acc_reg;
        ma_y   = acc_reg;
        ma_sub = 1'b0;
        case (state_reg)
            S_DIVADD: ma_y = t1_reg;
            S_MULADD: ma_y = a_reg;
            S_EXT_T:
            begin
                ma_x   = t0_reg;
                ma_y   = acc_reg;
                ma_sub = 1'b1;
            end
            default:
            begin
                ma_x   = acc_reg;
                ma_y   = acc_reg;
                ma_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        stage_next = stage_reg;
        ext_next   = ext_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        m_next     = m_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        div_start  = 1'b0;
        div_n      = x_reg;
        div_d      = y_reg;
        div_ext    = 1'b0;
        div_phase  = P_GCD;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next     = dividend;
                    b_next     = divisor;
                    m_next     = modulus;
                    x_next     = dividend;
                    y_next     = divisor;
                    stage_next = 1'b0;
                    if (modulus == '0)
                    begin
                        res_next.solution        = '0;
                        res_next.reduced_modulus = '0;
                        res_next.no_solution     = 1'b1;
                        state_next               = S_DONE;
                    end
                    else
                    begin
                        state_next = S_GCD_CHK;
                    end
                end
            end

            S_GCD_CHK:
            begin
                if (y_reg == '0)
                begin
                    if (!stage_reg)
                    begin
                        // gcd of the two inputs is in x; fold in the modulus
                        stage_next = 1'b1;
                        y_next     = m_reg;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_n     = a_reg;
                        div_d     = x_reg;
                        div_phase = P_QA;
                    end
                end
                else
                begin
                    div_start = 1'b1;
                    div_n     = x_reg;
                    div_d     = y_reg;
                    div_phase = P_GCD;
                end
            end

            S_ALIGN:
            begin
                if (d_dbl <= {1'b0, n_reg})
                begin
                    d_next   = d_dbl;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (qbit)
                begin
                    n_next = n_reg - d_reg[W-1:0];
                end
                q_next = {q_reg[W-2:0], qbit};
                d_next = d_reg >> 1;
                if (ext_reg)
                begin
                    // Horner accumulation of quotient times t1, modulo m
                    acc_next   = ma_r;
                    bit_next   = qbit;
                    state_next = S_DIVADD;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            S_DIVADD:
            begin
                if (bit_reg)
                begin
                    acc_next = ma_r;
                end
                if (cnt_reg == '0)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_DIV;
                end
            end

            S_NEXT:
            begin
                case (phase_reg)
                    P_GCD:
                    begin
                        x_next     = y_reg;
                        y_next     = n_reg;
                        state_next = S_GCD_CHK;
                    end
                    P_QA:
                    begin
                        a_next    = q_reg;
                        div_start = 1'b1;
                        div_n     = b_reg;
                        div_d     = x_reg;
                        div_phase = P_QB;
                    end
                    P_QB:
                    begin
                        b_next    = q_reg;
                        div_start = 1'b1;
                        div_n     = m_reg;
                        div_d     = x_reg;
                        div_phase = P_QM;
                    end
                    P_QM:
                    begin
                        m_next    = q_reg;
                        div_start = 1'b1;
                        div_n     = b_reg;
                        div_d     = q_reg;
                        div_phase = P_BMOD;
                    end
                    P_BMOD:
                    begin
                        r0_next    = m_reg;
                        r1_next    = n_reg;
                        t0_next    = '0;
                        t1_next    = (m_reg == W'(1)) ? '0 : W'(1);
                        state_next = S_EXT_CHK;
                    end
                    P_EXT:
                    begin
                        r0_next    = r1_reg;
                        r1_next    = n_reg;
                        state_next = S_EXT_T;
                    end
                    P_AMOD:
                    begin
                        a_next     = n_reg;
                        acc_next   = '0;
                        cnt_next   = CW'(W - 1);
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_EXT_T:
            begin
                t0_next    = t1_reg;
                t1_next    = ma_r;
                state_next = S_EXT_CHK;
            end

            S_EXT_CHK:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg != W'(1))
                    begin
                        res_next.solution        = '0;
                        res_next.reduced_modulus = m_reg;
                        res_next.no_solution     = 1'b1;
                        state_next               = S_DONE;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_n     = a_reg;
                        div_d     = m_reg;
                        div_phase = P_AMOD;
                    end
                end
                else
                begin
                    div_start = 1'b1;
                    div_n     = r0_reg;
                    div_d     = r1_reg;
                    div_ext   = 1'b1;
                    div_phase = P_EXT;
                end
            end

            S_MUL:
            begin
                acc_next   = ma_r;
                state_next = S_MULADD;
            end

            S_MULADD:
            begin
                // t0 holds the inverse; its bits are taken from the top down
                if (t0_reg[cnt_reg])
                begin
                    acc_next = ma_r;
                end
                if (cnt_reg == '0)
                begin
                    res_next.solution        = t0_reg[cnt_reg] ? ma_r : acc_reg;
                    res_next.reduced_modulus = m_reg;
                    res_next.no_solution     = 1'b0;
                    state_next               = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_MUL;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (div_start)
        begin
            n_next     = div_n;
            d_next     = {1'b0, div_d};
            q_next     = '0;
            cnt_next   = '0;
            acc_next   = '0;
            ext_next   = div_ext;
            phase_next = div_phase;
            state_next = S_ALIGN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= P_GCD;
            stage_reg <= 1'b0;
            ext_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            ext_reg   <= ext_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule
